### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/cce_pkg.sv
`default_nettype none

package cce_pkg;

   localparam int CodeBytes = 13;
   localparam int PlainBits = CodeBytes * 8;
   localparam int CodeBits  = 100;
   localparam int CodeChars = 20;
   localparam int SymBits   = 5;
   localparam int CheckBit  = 98;

   localparam int QueueDepthDefault = 2;

   typedef logic [CodeBits-1:0]  code_type;
   typedef logic [PlainBits-1:0] plain_type;
   typedef logic [SymBits-1:0]   sym_type;
   typedef logic [6:0]           char_type;
   typedef logic [4:0]           pos_type;
   typedef logic [3:0]           byte_idx_type;

   localparam pos_type      LastPos  = pos_type'(CodeChars - 1);
   localparam byte_idx_type LastByte = byte_idx_type'(CodeBytes - 1);

   localparam logic [31:0] FnvOffset = 32'h811C_9DC5;
   localparam logic [31:0] FnvPrime  = 32'h0100_0193;

   // keystream, byte 0 in the low bits
   localparam plain_type KeyStream = 104'h03_9C_62_F1_3D_B6_08_E4_7B_2E_91_C3_5A;

   // base32 alphabet without 0, I, L and O
   localparam char_type SymChars [32] = '{
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
      7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51, 7'h52,
      7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
   };

endpackage

`default_nettype wire

### rtl/cce_req_if.sv
`default_nettype none

interface cce_req_if;
   logic        valid;
   logic        ready;
   logic [6:0]  title;
   logic [10:0] species_0;
   logic [10:0] species_1;
   logic [10:0] species_2;
   logic [10:0] species_3;
   logic [10:0] species_4;
   logic [10:0] species_5;
   logic [5:0]  shiny_flags;
   logic [15:0] trainer_id;

   modport source (
      output valid, title, species_0, species_1, species_2, species_3, species_4,
             species_5, shiny_flags, trainer_id,
      input  ready
   );

   modport sink (
      input  valid, title, species_0, species_1, species_2, species_3, species_4,
             species_5, shiny_flags, trainer_id,
      output ready
   );
endinterface

`default_nettype wire

### rtl/cce_rsp_if.sv
`default_nettype none

interface cce_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] symbol;
   logic [6:0] character;
   logic [4:0] position;
   logic       last;

   modport source (
      output valid, symbol, character, position, last,
      input  ready
   );

   modport sink (
      input  valid, symbol, character, position, last,
      output ready
   );
endinterface

`default_nettype wire

### rtl/checked_code_encoder.sv
`default_nettype none

// checked code encoder: each request (title, six species, shiny flags, trainer id)
// becomes a 100-bit keyed code with a 2-bit fnv-1a checksum, delivered as twenty
// responses, one per base32 character, lowest bit group first, last set on
// position 19. the front end packs the record and runs the hash one byte per
// cycle through a single 32-bit multiplier and then hands the code over; a small
// queue decouples it from the character emitter. the emitter sends one character
// per cycle while the sink is ready, so the character emitter sets the sustained
// rate; the front end already takes the next request while the previous code is
// still being emitted. no registers to program, no state kept between requests.
module checked_code_encoder #(
   parameter int QueueDepth = cce_pkg::QueueDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   cce_req_if.sink   req_chan,
   cce_rsp_if.source rsp_chan
);

   // front end to queue
   logic              push_valid;
   logic              push_ready;
   cce_pkg::code_type push_code;

   // queue to emitter
   logic              pop_valid;
   logic              pop_ready;
   cce_pkg::code_type pop_code;

   // pack, hash, key and checksum
   cce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_code  (push_code)
   );

   // finished codes wait here while the emitter is busy
   cce_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_code  (push_code),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_code   (pop_code)
   );

   // one character per cycle into the response register while the sink is ready
   cce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_code  (pop_code),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/cce_front.sv
`default_nettype none

`include "assert_macros.svh"

module cce_front (
   input  wire logic          clock,
   input  wire logic          reset,
   cce_req_if.sink            req_chan,
   output logic               push_valid,
   input  wire logic          push_ready,
   output cce_pkg::code_type  push_code
);

   typedef enum logic [2:0] {
      FrontIdle = 3'b001,
      FrontHash = 3'b010,
      FrontPush = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   cce_pkg::byte_idx_type cnt_ff, cnt_in;
   cce_pkg::plain_type    plain_ff, plain_in;
   logic [31:0]           hash_ff, hash_in;

   logic [7:0]         cur_byte;
   logic [31:0]        fold16, fold8, fold4, fold2;
   cce_pkg::plain_type keyed;

   // byte 12 only carries bits 96-97, upper bits of the buffer are zero
   assign cur_byte = plain_ff[{cnt_ff, 3'b000} +: 8];

   assign fold16 = hash_ff ^ (hash_ff >> 16);
   assign fold8  = fold16 ^ (fold16 >> 8);
   assign fold4  = fold8 ^ (fold8 >> 4);
   assign fold2  = fold4 ^ (fold4 >> 2);

   assign keyed = plain_ff ^ cce_pkg::KeyStream;

   assign req_chan.ready = (state_ff == FrontIdle);
   assign push_valid     = (state_ff == FrontPush);
   assign push_code      = {fold2[1:0], keyed[cce_pkg::CheckBit-1:0]};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      plain_in = plain_ff;
      hash_in  = hash_ff;
      unique case (state_ff)
         FrontIdle: begin
            if (req_chan.valid) begin
               plain_in = {6'b0, 1'b0, req_chan.trainer_id, req_chan.shiny_flags,
                           req_chan.species_5, req_chan.species_4, req_chan.species_3,
                           req_chan.species_2, req_chan.species_1, req_chan.species_0,
                           req_chan.title, 2'b00};
               hash_in  = cce_pkg::FnvOffset;
               cnt_in   = '0;
               state_in = FrontHash;
            end
         end
         FrontHash: begin
            hash_in = (hash_ff ^ {24'b0, cur_byte}) * cce_pkg::FnvPrime;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == cce_pkg::LastByte) begin
               state_in = FrontPush;
            end
         end
         FrontPush: begin
            if (push_ready) begin
               state_in = FrontIdle;
            end
         end
         default: state_in = FrontIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrontIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      plain_ff <= plain_in;
      hash_ff  <= hash_in;
   end

   `ASSERT_IMPL(a_cnt_range, state_ff == FrontHash, cnt_ff <= cce_pkg::LastByte,
      "byte count out of range")
   `ASSERT_NEXT(a_hash_done, state_ff == FrontHash && cnt_ff == cce_pkg::LastByte,
      state_ff == FrontPush, "hash did not finish after last byte")

endmodule

`default_nettype wire

### rtl/cce_queue.sv
`default_nettype none

`include "assert_macros.svh"

module cce_queue #(
   parameter int Depth = cce_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire cce_pkg::code_type push_code,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output cce_pkg::code_type      pop_code
);

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);

   cce_pkg::code_type   mem_ff [Depth];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntBits'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_code   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_code;
      end
   end

   `ASSERT_NEXT(a_fill_up, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1,
      "queue count did not grow on push")
   `ASSERT_IMPL(a_ptr_gap, count_ff == '0, wr_ptr_ff == rd_ptr_ff,
      "empty queue with pointers apart")

endmodule

`default_nettype wire

### rtl/cce_back.sv
`default_nettype none

`include "assert_macros.svh"

module cce_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire cce_pkg::code_type pop_code,
   cce_rsp_if.source              rsp_chan
);

   logic                 active_ff, active_in;
   cce_pkg::code_type    code_ff, code_in;
   cce_pkg::pos_type     pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cce_pkg::sym_type     symbol_ff, symbol_in;
   cce_pkg::char_type    char_ff, char_in;
   cce_pkg::pos_type     position_ff, position_in;
   logic                 last_ff, last_in;
   logic                 advance, at_last;

   assign advance   = active_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign at_last   = (pos_ff == cce_pkg::LastPos);
   assign pop_ready = !active_ff || (advance && at_last);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.symbol    = symbol_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.position  = position_ff;
   assign rsp_chan.last      = last_ff;

   always_comb begin
      active_in    = active_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      symbol_in    = symbol_ff;
      char_in      = char_ff;
      position_in  = position_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         symbol_in    = code_ff[cce_pkg::SymBits-1:0];
         char_in      = cce_pkg::SymChars[code_ff[cce_pkg::SymBits-1:0]];
         position_in  = pos_ff;
         last_in      = at_last;
         code_in      = code_ff >> cce_pkg::SymBits;
         pos_in       = pos_ff + 5'd1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         active_in = 1'b1;
         code_in   = pop_code;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      pos_ff      <= pos_in;
      symbol_ff   <= symbol_in;
      char_ff     <= char_in;
      position_ff <= position_in;
      last_ff     <= last_in;
   end

   `ASSERT_NEXT(a_code_end, advance && at_last && !pop_valid, !active_ff,
      "emitter still busy after last character")

endmodule

`default_nettype wire

### bench/code_check.sv
`timescale 1ns / 1ps

module code_check (
   input  logic clock,
   input  logic reset,
   cce_req_if   req_mon,
   cce_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [4:0] symbol;
      logic [6:0] character;
      logic [4:0] position;
      logic       last;
   } code_char_type;

   localparam logic [31:0]  HashSeed = 32'd2166136261;
   localparam logic [31:0]  HashMult = 32'd16777619;
   // byte 0 of the keystream sits in the low bits
   localparam logic [103:0] KeyBytes = {8'h03, 8'h9C, 8'h62, 8'hF1, 8'h3D, 8'hB6, 8'h08,
                                        8'hE4, 8'h7B, 8'h2E, 8'h91, 8'hC3, 8'h5A};
   localparam logic [255:0] Alphabet = "123456789ABCDEFGHJKMNPQRSTUVWXYZ";

   code_char_type code_chars_due[$];
   int            mismatches = 0;

   function automatic logic [99:0] encode_team(
      input logic [6:0]  title,
      input logic [10:0] sp0, sp1, sp2, sp3, sp4, sp5,
      input logic [5:0]  flags,
      input logic [15:0] id
   );
      logic [103:0] plain;
      logic [31:0]  hash;
      logic [7:0]   octet;
      int           i;
      plain        = '0;
      plain[8:2]   = title;
      plain[19:9]  = sp0;
      plain[30:20] = sp1;
      plain[41:31] = sp2;
      plain[52:42] = sp3;
      plain[63:53] = sp4;
      plain[74:64] = sp5;
      plain[80:75] = flags;
      plain[96:81] = id;
      hash = HashSeed;
      for (i = 0; i < 13; i++) begin
         octet = plain[i*8 +: 8];
         // only the two bits below the checksum count in the last byte
         if (i == 12) octet = octet & 8'h03;
         hash = (hash ^ {24'h0, octet}) * HashMult;
      end
      hash = hash ^ (hash >> 16);
      hash = hash ^ (hash >> 8);
      hash = hash ^ (hash >> 4);
      hash = hash ^ (hash >> 2);
      plain = plain ^ KeyBytes;
      plain[99:98] = hash[1:0];
      return plain[99:0];
   endfunction

   always @(posedge clock) begin
      logic [99:0]   code;
      logic [7:0]    glyph;
      code_char_type want;
      code_char_type seen;
      int            k;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            code = encode_team(req_mon.title, req_mon.species_0, req_mon.species_1,
                               req_mon.species_2, req_mon.species_3, req_mon.species_4,
                               req_mon.species_5, req_mon.shiny_flags, req_mon.trainer_id);
            for (k = 0; k < 20; k++) begin
               want.symbol    = code[k*5 +: 5];
               glyph          = Alphabet[8*(31 - int'(want.symbol)) +: 8];
               want.character = glyph[6:0];
               want.position  = 5'(k);
               want.last      = (k == 19);
               code_chars_due.push_back(want);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.symbol, rsp_mon.character, rsp_mon.position, rsp_mon.last};
            if (code_chars_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected character sym %0d chr %0d pos %0d last %0d",
                           $realtime, seen.symbol, seen.character, seen.position, seen.last);
            end else begin
               want = code_chars_due.pop_front();
               if (seen.symbol !== want.symbol || seen.character !== want.character ||
                   seen.position !== want.position || seen.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch exp sym %0d chr %0d pos %0d last %0d",
                            $realtime, want.symbol, want.character, want.position,
                            want.last);
                     $display(", got sym %0d chr %0d pos %0d last %0d",
                              seen.symbol, seen.character, seen.position, seen.last);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= code_chars_due.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

   // one team record as it goes over the request channel
   typedef struct packed {
      logic [6:0]       title;
      logic [5:0][10:0] species;
      logic [5:0]       flags;
      logic [15:0]      id;
   } team_rec_type;

   localparam int IdleLimit   = 2000;
   localparam int RandomTeams = 500;
   localparam int PhaseTeams  = 100;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   bit   quiet_send = 0;
   bit   quiet_recv = 0;

   cce_req_if req_chan ();
   cce_rsp_if rsp_chan ();

   checked_code_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   code_check code_mon (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // present one request, after a random gap unless the sender is in a quiet stretch;
   // valid is only lowered when a gap follows, so back-to-back requests keep it high
   task automatic send_team(input team_rec_type r);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.title       <= r.title;
      req_chan.species_0   <= r.species[0];
      req_chan.species_1   <= r.species[1];
      req_chan.species_2   <= r.species[2];
      req_chan.species_3   <= r.species[3];
      req_chan.species_4   <= r.species[4];
      req_chan.species_5   <= r.species[5];
      req_chan.shiny_flags <= r.flags;
      req_chan.trainer_id  <= r.id;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off new requests until every code character has come out;
   // the count is registered, so it lags the accepting edge
   task automatic drain_codes();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly uniform content; one in four records pins each field, with one chance in three, to zero or all ones
   function automatic team_rec_type random_team();
      team_rec_type r;
      bit           corner;
      int           m;
      corner = ($urandom_range(3) == 0);
      r.title = 7'($urandom);
      for (m = 0; m < 6; m++) r.species[m] = 11'($urandom);
      r.flags = 6'($urandom);
      r.id    = 16'($urandom);
      if (corner) begin
         if ($urandom_range(2) == 0) r.title = $urandom_range(1) ? '1 : '0;
         for (m = 0; m < 6; m++)
            if ($urandom_range(2) == 0) r.species[m] = $urandom_range(1) ? '1 : '0;
         if ($urandom_range(2) == 0) r.flags = $urandom_range(1) ? '1 : '0;
         if ($urandom_range(2) == 0) r.id = $urandom_range(1) ? '1 : '0;
      end
      return r;
   endfunction

   // response side: random stall before each character, none in quiet stretches
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_recv ? 0 : $urandom_range(10);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // watchdog on cycles in which neither channel moves anything
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      team_rec_type r;
      int           f;
      int           n;
      int           phase;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.title       <= '0;
      req_chan.species_0   <= '0;
      req_chan.species_1   <= '0;
      req_chan.species_2   <= '0;
      req_chan.species_3   <= '0;
      req_chan.species_4   <= '0;
      req_chan.species_5   <= '0;
      req_chan.shiny_flags <= '0;
      req_chan.trainer_id  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: all zero, all ones, alternating bit patterns
      send_team('0);
      send_team('1);
      send_team(95'({48{2'b01}}));
      send_team(95'({48{2'b10}}));
      // each field at its maximum with everything else zero
      for (f = 0; f < 9; f++) begin
         r = '0;
         case (f)
            0:       r.title = '1;
            7:       r.flags = '1;
            8:       r.id    = '1;
            default: r.species[f-1] = '1;
         endcase
         send_team(r);
      end
      // single flag bits, one per team member
      for (f = 0; f < 6; f++) begin
         r = '0;
         r.flags[f] = 1'b1;
         send_team(r);
      end
      // lowest and highest single-bit id with species near the top
      r = '0;
      r.id = 16'h0001;
      r.species = {6{11'h7FE}};
      send_team(r);
      r.id = 16'h8000;
      send_team(r);

      // full drain before the random part
      drain_codes();

      // random part in phases; first phase has no idling on either side,
      // later ones pick per side, and some phases drain first
      for (phase = 0; phase < RandomTeams / PhaseTeams; phase++) begin
         if (phase == 0) begin
            quiet_send = 1;
            quiet_recv = 1;
         end else begin
            quiet_send = ($urandom_range(2) == 0);
            quiet_recv = ($urandom_range(2) == 0);
         end
         if ($urandom_range(1) == 0) drain_codes();
         for (n = 0; n < PhaseTeams; n++) send_team(random_team());
      end
      req_chan.valid <= 1'b0;
      quiet_recv = 0;

      // let the last code come out, then watch for stray characters
      drain_codes();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/cce_pkg.sv
rtl/cce_req_if.sv
rtl/cce_rsp_if.sv
rtl/cce_front.sv
rtl/cce_queue.sv
rtl/cce_back.sv
rtl/checked_code_encoder.sv
bench/code_check.sv
bench/tb.sv
